// ===== rtl/lzbd_pkg.sv =====
// shared constants, types and command/status bundles for the backward lz decompressor
package lzbd_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int WP_W         = $clog2(WINDOW_DEPTH);
   localparam int OUT_LANES    = 8;
   localparam int LANE_CNT_W   = 4;

   localparam logic [3:0] FIRST_BITS_MAX = 4'd8;
   localparam logic [3:0] BYTE_BITS      = 4'd8;

   typedef enum logic [1:0] {
      CSR_FIRST_BYTE_BITS = 2'd0,
      CSR_CHECKSUM_SEED   = 2'd1,
      CSR_OUTPUT_LENGTH   = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_START    = 1'b0,
      CMD_CONTINUE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ERROR    = 2'd1,
      STATUS_CHECKSUM = 2'd2
   } status_code_type;

   typedef enum logic [2:0] {
      RUN_TWO,
      RUN_THREE,
      RUN_FOUR,
      RUN_LEN8,
      RUN_RAW3,
      RUN_RAW8
   } run_sel_type;

   typedef enum logic {
      PUT_LITERAL = 1'b0,
      PUT_HISTORY = 1'b1
   } put_sel_type;

   typedef struct packed {
      logic            load_start;
      logic            load_cont;
      logic            take_bit;
      logic            enter;
      logic [3:0]      enter_bits;
      logic            set_run;
      run_sel_type     run_sel;
      logic            load_offset;
      logic            mem_read;
      logic            put;
      put_sel_type     put_sel;
      logic            emit;
      logic            emit_done;
      status_code_type emit_status;
   } cmd_type;

   typedef struct packed {
      logic       bits_empty;
      logic       last;
      logic       field_last;
      logic [1:0] v_low;
      logic       raw3_bad;
      logic       raw8_bad;
      logic       copy_bad;
      logic       run_last;
      logic       lane_fill;
      logic       lanes_empty;
      logic       bytes_zero;
      logic       xor_nonzero;
      logic       ol_zero;
      logic       slot_free;
   } status_type;

endpackage

// ===== rtl/lzbd_if.sv =====
// valid/ready channel interfaces for input items, results and register writes
interface lzbd_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] comp_byte;
   logic       final_byte;
   modport source (output valid, command, comp_byte, final_byte, input ready);
   modport sink (input valid, command, comp_byte, final_byte, output ready);
endinterface

interface lzbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_bytes;
   logic [3:0]  byte_count;
   logic        section_done;
   logic [1:0]  status;
   modport source (output valid, out_bytes, byte_count, section_done, status, input ready);
   modport sink (input valid, out_bytes, byte_count, section_done, status, output ready);
endinterface

interface lzbd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lz_backward_bitstream_decompressor.sv =====
// top level: backward lz bitstream decompressor with 4096-byte history
// an input item is accepted, then its bits are consumed one at a time (up to 8);
// each byte copied from the history memory takes a registered read then a write,
// each token end and each result emitted (after any output stall) has its own state,
// and the item closes with an empty-buffer check and a flush
// one item is in work at a time; results wait in an output register, stalling the parse
// synchronous active-high reset clears control, registers to defaults; no memory clear
module lz_backward_bitstream_decompressor (
   input logic        clock,
   input logic        reset,
   lzbd_req_if.sink   req_ch,
   lzbd_rsp_if.source rsp_ch,
   lzbd_csr_if.sink   csr_ch
);

   lzbd_pkg::cmd_type    cmd;
   lzbd_pkg::status_type st;

   assign csr_ch.ready = 1'b1;

   lzbd_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .st          (st),
      .cmd         (cmd)
   );

   lzbd_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .in_byte          (req_ch.comp_byte),
      .in_last          (req_ch.final_byte),
      .csr_valid        (csr_ch.valid),
      .csr_index        (csr_ch.index),
      .csr_data         (csr_ch.data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_out_bytes    (rsp_ch.out_bytes),
      .rsp_byte_count   (rsp_ch.byte_count),
      .rsp_section_done (rsp_ch.section_done),
      .rsp_status       (rsp_ch.status)
   );

endmodule

// ===== rtl/lzbd_datapath.sv =====
// bit buffer, field accumulator, counters, history memory and result register
module lzbd_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lzbd_pkg::cmd_type    cmd,
   output lzbd_pkg::status_type st,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [63:0]          rsp_out_bytes,
   output logic [3:0]           rsp_byte_count,
   output logic                 rsp_section_done,
   output logic [1:0]           rsp_status
);

   logic [3:0]  first_bits_ff, first_bits_in;
   logic [7:0]  seed_ff, seed_in;
   logic [31:0] out_len_ff, out_len_in;

   logic [7:0]  buf_ff, buf_in;
   logic [3:0]  nbits_ff, nbits_in;
   logic        last_ff, last_in;
   logic [7:0]  xor_ff, xor_in;
   logic [15:0] accum_ff, accum_in;
   logic [3:0]  fbl_ff, fbl_in;
   logic [8:0]  run_ff, run_in;
   logic [lzbd_pkg::WP_W-1:0] off_ff, off_in;
   logic [lzbd_pkg::WP_W-1:0] wp_ff, wp_in;
   logic [31:0] left_ff, left_in;
   logic [63:0] lane_word_ff, lane_word_in;
   logic [lzbd_pkg::LANE_CNT_W-1:0] lane_cnt_ff, lane_cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_bytes_ff, rsp_bytes_in;
   logic [3:0]  rsp_cnt_ff, rsp_cnt_in;
   logic        rsp_done_ff, rsp_done_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic [7:0]  hist_mem [lzbd_pkg::WINDOW_DEPTH];
   logic [7:0]  rdata_ff;
   logic [lzbd_pkg::WP_W-1:0] rd_addr;

   logic [15:0] v_next;
   logic [8:0]  raw3_len, raw8_len, run_set;
   logic [32:0] reach;
   logic [7:0]  put_byte;
   logic [5:0]  lane_shift;

   assign v_next   = {accum_ff[14:0], buf_ff[0]};
   assign raw3_len = {6'd0, v_next[2:0]} + 9'd1;
   assign raw8_len = {1'b0, v_next[7:0]} + 9'd9;
   // offset field plus one, on top of bytes still to come
   assign reach    = {1'b0, left_ff} + {21'd0, v_next[11:0]} + 33'd1;
   assign rd_addr  = wp_ff - off_ff - {{(lzbd_pkg::WP_W-1){1'b0}}, 1'b1};
   assign put_byte = (cmd.put_sel == lzbd_pkg::PUT_HISTORY) ? rdata_ff : v_next[7:0];
   assign lane_shift = {lane_cnt_ff[2:0], 3'b000};

   always_comb begin
      case (cmd.run_sel)
         lzbd_pkg::RUN_TWO:   run_set = 9'd2;
         lzbd_pkg::RUN_THREE: run_set = 9'd3;
         lzbd_pkg::RUN_FOUR:  run_set = 9'd4;
         lzbd_pkg::RUN_LEN8:  run_set = {1'b0, v_next[7:0]} + 9'd1;
         lzbd_pkg::RUN_RAW3:  run_set = raw3_len;
         default:             run_set = raw8_len;
      endcase
   end

   always_comb begin
      st.bits_empty  = (nbits_ff == 4'd0);
      st.last        = last_ff;
      st.field_last  = (fbl_ff == 4'd1);
      st.v_low       = v_next[1:0];
      st.raw3_bad    = ({23'd0, raw3_len} > left_ff);
      st.raw8_bad    = ({23'd0, raw8_len} > left_ff);
      st.copy_bad    = (reach > {1'b0, out_len_ff}) || ({23'd0, run_ff} > left_ff);
      st.run_last    = (run_ff == 9'd1);
      st.lane_fill   = (lane_cnt_ff == lzbd_pkg::LANE_CNT_W'(lzbd_pkg::OUT_LANES - 1));
      st.lanes_empty = (lane_cnt_ff == '0);
      st.bytes_zero  = (left_ff == 32'd0);
      st.xor_nonzero = (xor_ff != 8'd0);
      st.ol_zero     = (out_len_ff == 32'd0);
      st.slot_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      first_bits_in = first_bits_ff;
      seed_in       = seed_ff;
      out_len_in    = out_len_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lzbd_pkg::CSR_FIRST_BYTE_BITS: first_bits_in = csr_data[3:0];
            lzbd_pkg::CSR_CHECKSUM_SEED:   seed_in       = csr_data[7:0];
            lzbd_pkg::CSR_OUTPUT_LENGTH:   out_len_in    = csr_data;
            default:                       first_bits_in = first_bits_ff;
         endcase
      end

      buf_in       = buf_ff;
      nbits_in     = nbits_ff;
      last_in      = last_ff;
      xor_in       = xor_ff;
      accum_in     = accum_ff;
      fbl_in       = fbl_ff;
      run_in       = run_ff;
      off_in       = off_ff;
      wp_in        = wp_ff;
      left_in      = left_ff;
      lane_word_in = lane_word_ff;
      lane_cnt_in  = lane_cnt_ff;

      if (cmd.load_start) begin
         left_in  = out_len_ff;
         xor_in   = seed_ff ^ in_byte;
         wp_in    = '0;
         run_in   = 9'd0;
         buf_in   = in_byte;
         last_in  = in_last;
         nbits_in = (first_bits_ff > lzbd_pkg::FIRST_BITS_MAX) ? lzbd_pkg::FIRST_BITS_MAX
                                                               : first_bits_ff;
      end
      if (cmd.load_cont) begin
         xor_in   = xor_ff ^ in_byte;
         buf_in   = in_byte;
         last_in  = in_last;
         nbits_in = lzbd_pkg::BYTE_BITS;
      end
      if (cmd.take_bit) begin
         buf_in   = {1'b0, buf_ff[7:1]};
         nbits_in = nbits_ff - 4'd1;
         accum_in = v_next;
         fbl_in   = fbl_ff - 4'd1;
      end
      if (cmd.enter) begin
         accum_in = 16'd0;
         fbl_in   = cmd.enter_bits;
      end
      if (cmd.set_run) begin
         run_in = run_set;
      end
      if (cmd.load_offset) begin
         off_in = v_next[lzbd_pkg::WP_W-1:0];
      end
      if (cmd.put) begin
         wp_in        = wp_ff + {{(lzbd_pkg::WP_W-1){1'b0}}, 1'b1};
         left_in      = left_ff - 32'd1;
         run_in       = run_ff - 9'd1;
         lane_word_in = lane_word_ff | ({56'd0, put_byte} << lane_shift);
         lane_cnt_in  = lane_cnt_ff + {{(lzbd_pkg::LANE_CNT_W-1){1'b0}}, 1'b1};
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_bytes_in  = lane_word_ff;
         rsp_cnt_in    = lane_cnt_ff;
         rsp_done_in   = cmd.emit_done;
         rsp_status_in = cmd.emit_status;
         lane_word_in  = 64'd0;
         lane_cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_bits_ff <= lzbd_pkg::FIRST_BITS_MAX;
         seed_ff       <= 8'd0;
         out_len_ff    <= 32'd0;
         nbits_ff      <= 4'd0;
         fbl_ff        <= 4'd0;
         lane_word_ff  <= 64'd0;
         lane_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_bits_ff <= first_bits_in;
         seed_ff       <= seed_in;
         out_len_ff    <= out_len_in;
         nbits_ff      <= nbits_in;
         fbl_ff        <= fbl_in;
         lane_word_ff  <= lane_word_in;
         lane_cnt_ff   <= lane_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      buf_ff        <= buf_in;
      last_ff       <= last_in;
      xor_ff        <= xor_in;
      accum_ff      <= accum_in;
      run_ff        <= run_in;
      off_ff        <= off_in;
      wp_ff         <= wp_in;
      left_ff       <= left_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
   end

   // history window, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         hist_mem[wp_ff] <= put_byte;
      end
      if (cmd.mem_read) begin
         rdata_ff <= hist_mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_bytes    = rsp_bytes_ff;
   assign rsp_byte_count   = rsp_cnt_ff;
   assign rsp_section_done = rsp_done_ff;
   assign rsp_status       = rsp_status_ff;

   a_put_has_lane: assert property (@(posedge clock) disable iff (reset)
      cmd.put |-> (lane_cnt_ff < lzbd_pkg::LANE_CNT_W'(lzbd_pkg::OUT_LANES)))
      else $error("byte put with all lanes full");
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");
   a_bit_avail: assert property (@(posedge clock) disable iff (reset)
      cmd.take_bit |-> (nbits_ff != 4'd0))
      else $error("bit taken from empty buffer");
   a_lanes_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (lane_cnt_ff == '0))
      else $error("lanes not cleared after emit");

endmodule

// ===== rtl/lzbd_controller.sv =====
// token parser and sequencer driving the datapath
module lzbd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_ready,
   input  lzbd_pkg::status_type st,
   output lzbd_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_BIT,
      S_CPRD,
      S_CPWR,
      S_TEND,
      S_EMIT,
      S_FLUSH
   } state_type;

   typedef enum logic [3:0] {
      P_IDLE,
      P_HEAD1,
      P_HEAD2S,
      P_HEAD2L,
      P_RAW3,
      P_RAW8,
      P_LEN8,
      P_OFFSET,
      P_LITERAL
   } phase_type;

   state_type                 state_ff, state_in;
   state_type                 ret_ff, ret_in;
   phase_type                 phase_ff, phase_in;
   logic                      done_ff, done_in;
   lzbd_pkg::status_code_type code_ff, code_in;
   state_type                 after_put;

   always_comb begin
      cmd             = '0;
      cmd.run_sel     = lzbd_pkg::RUN_TWO;
      cmd.put_sel     = lzbd_pkg::PUT_LITERAL;
      cmd.emit_done   = done_ff;
      cmd.emit_status = code_ff;
      state_in        = state_ff;
      ret_in          = ret_ff;
      phase_in        = phase_ff;
      done_in         = done_ff;
      code_in         = code_ff;
      after_put       = S_BIT;
      req_ready       = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == lzbd_pkg::CMD_START) begin
                  if (st.ol_zero) begin
                     // empty section ends at once
                     phase_in = P_IDLE;
                     done_in  = 1'b1;
                     code_in  = lzbd_pkg::STATUS_OK;
                     ret_in   = S_IDLE;
                     state_in = S_EMIT;
                  end else begin
                     cmd.load_start = 1'b1;
                     cmd.enter      = 1'b1;
                     cmd.enter_bits = 4'd1;
                     phase_in       = P_HEAD1;
                     state_in       = S_BIT;
                  end
               end else if (phase_ff != P_IDLE) begin
                  cmd.load_cont = 1'b1;
                  state_in      = S_BIT;
               end
            end
         end
         S_BIT: begin
            if (phase_ff == P_IDLE) begin
               state_in = S_FLUSH;
            end else if (st.bits_empty) begin
               if (st.last) begin
                  phase_in = P_IDLE;
                  done_in  = 1'b1;
                  code_in  = lzbd_pkg::STATUS_ERROR;
                  ret_in   = S_FLUSH;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_FLUSH;
               end
            end else begin
               cmd.take_bit = 1'b1;
               if (st.field_last) begin
                  case (phase_ff) inside
                     P_HEAD1: begin
                        cmd.enter = 1'b1;
                        if (st.v_low[0]) begin
                           cmd.enter_bits = 4'd2;
                           phase_in       = P_HEAD2L;
                        end else begin
                           cmd.enter_bits = 4'd1;
                           phase_in       = P_HEAD2S;
                        end
                     end
                     P_HEAD2S: begin
                        cmd.enter = 1'b1;
                        if (st.v_low[0]) begin
                           cmd.set_run    = 1'b1;
                           cmd.run_sel    = lzbd_pkg::RUN_TWO;
                           cmd.enter_bits = 4'd8;
                           phase_in       = P_OFFSET;
                        end else begin
                           cmd.enter_bits = 4'd3;
                           phase_in       = P_RAW3;
                        end
                     end
                     P_HEAD2L: begin
                        cmd.enter = 1'b1;
                        case (st.v_low)
                           2'd0: begin
                              cmd.set_run    = 1'b1;
                              cmd.run_sel    = lzbd_pkg::RUN_THREE;
                              cmd.enter_bits = 4'd9;
                              phase_in       = P_OFFSET;
                           end
                           2'd1: begin
                              cmd.set_run    = 1'b1;
                              cmd.run_sel    = lzbd_pkg::RUN_FOUR;
                              cmd.enter_bits = 4'd10;
                              phase_in       = P_OFFSET;
                           end
                           2'd2: begin
                              cmd.enter_bits = 4'd8;
                              phase_in       = P_LEN8;
                           end
                           default: begin
                              cmd.enter_bits = 4'd8;
                              phase_in       = P_RAW8;
                           end
                        endcase
                     end
                     P_LEN8: begin
                        cmd.set_run    = 1'b1;
                        cmd.run_sel    = lzbd_pkg::RUN_LEN8;
                        cmd.enter      = 1'b1;
                        cmd.enter_bits = 4'd12;
                        phase_in       = P_OFFSET;
                     end
                     P_RAW3, P_RAW8: begin
                        if ((phase_ff == P_RAW3) ? st.raw3_bad : st.raw8_bad) begin
                           phase_in = P_IDLE;
                           done_in  = 1'b1;
                           code_in  = lzbd_pkg::STATUS_ERROR;
                           ret_in   = S_FLUSH;
                           state_in = S_EMIT;
                        end else begin
                           cmd.set_run    = 1'b1;
                           cmd.run_sel    = (phase_ff == P_RAW3) ? lzbd_pkg::RUN_RAW3
                                                                 : lzbd_pkg::RUN_RAW8;
                           cmd.enter      = 1'b1;
                           cmd.enter_bits = 4'd8;
                           phase_in       = P_LITERAL;
                        end
                     end
                     P_OFFSET: begin
                        if (st.copy_bad) begin
                           phase_in = P_IDLE;
                           done_in  = 1'b1;
                           code_in  = lzbd_pkg::STATUS_ERROR;
                           ret_in   = S_FLUSH;
                           state_in = S_EMIT;
                        end else begin
                           cmd.load_offset = 1'b1;
                           state_in        = S_CPRD;
                        end
                     end
                     P_LITERAL: begin
                        cmd.put     = 1'b1;
                        cmd.put_sel = lzbd_pkg::PUT_LITERAL;
                        if (st.run_last) begin
                           after_put = S_TEND;
                        end else begin
                           cmd.enter      = 1'b1;
                           cmd.enter_bits = 4'd8;
                           after_put      = S_BIT;
                        end
                        if (st.lane_fill) begin
                           done_in  = 1'b0;
                           code_in  = lzbd_pkg::STATUS_OK;
                           ret_in   = after_put;
                           state_in = S_EMIT;
                        end else begin
                           state_in = after_put;
                        end
                     end
                     default: phase_in = P_IDLE;
                  endcase
               end
            end
         end
         S_CPRD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_CPWR;
         end
         S_CPWR: begin
            cmd.put     = 1'b1;
            cmd.put_sel = lzbd_pkg::PUT_HISTORY;
            after_put   = st.run_last ? S_TEND : S_CPRD;
            if (st.lane_fill) begin
               done_in  = 1'b0;
               code_in  = lzbd_pkg::STATUS_OK;
               ret_in   = after_put;
               state_in = S_EMIT;
            end else begin
               state_in = after_put;
            end
         end
         S_TEND: begin
            if (st.bytes_zero) begin
               phase_in = P_IDLE;
               done_in  = 1'b1;
               code_in  = st.xor_nonzero ? lzbd_pkg::STATUS_CHECKSUM : lzbd_pkg::STATUS_OK;
               ret_in   = S_FLUSH;
               state_in = S_EMIT;
            end else begin
               cmd.enter      = 1'b1;
               cmd.enter_bits = 4'd1;
               phase_in       = P_HEAD1;
               state_in       = S_BIT;
            end
         end
         S_EMIT: begin
            if (st.slot_free) begin
               cmd.emit = 1'b1;
               state_in = ret_ff;
            end
         end
         S_FLUSH: begin
            if (st.lanes_empty) begin
               state_in = S_IDLE;
            end else begin
               done_in  = 1'b0;
               code_in  = lzbd_pkg::STATUS_OK;
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
         code_ff  <= lzbd_pkg::STATUS_OK;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
         code_ff  <= code_in;
      end
   end

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !cmd.emit_done) |-> (cmd.emit_status == lzbd_pkg::STATUS_OK))
      else $error("error status on a result that does not end the section");
   a_done_idles: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.emit_done) |-> (phase_ff == P_IDLE))
      else $error("section end emitted while a token is still open");
   a_read_then_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CPRD) |=> (state_ff == S_CPWR))
      else $error("history read not followed by its write");

endmodule

// ===== dv/lz_backward_bitstream_decompressor_test.sv =====
// self-checking testbench for the backward lz bitstream decompressor
module lz_backward_bitstream_decompressor_test;

   localparam int STALL_LIMIT = 30000;
   localparam int DRAIN_CYCLES = 40;

   typedef enum logic [3:0] {
      P_IDLE, P_HEAD1, P_HEAD2S, P_HEAD2L, P_RAW3, P_RAW8, P_LEN8, P_OFFSET, P_LITERAL
   } parse_phase_type;

   typedef struct {
      logic [63:0]                         data;
      logic [3:0]                          count;
      logic                                done;
      lzbd_pkg::status_code_type           st;
   } out_word_type;

   logic clock;
   logic reset;

   lzbd_req_if req_ch ();
   lzbd_rsp_if rsp_ch ();
   lzbd_csr_if csr_ch ();

   lz_backward_bitstream_decompressor u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // expected output words, oldest first
   out_word_type expected_words[$];
   int           fail_count;
   int           items_sent;
   int           rsp_gap;
   int           hold_cycles;
   int           stall_count;

   // decoder mirror
   logic [3:0]                cfg_first_bits;
   logic [7:0]                cfg_seed;
   logic [31:0]               cfg_out_len;
   logic [7:0]                hist_mem [lzbd_pkg::WINDOW_DEPTH];
   logic [31:0]               bytes_left;
   logic [7:0]                bit_buf;
   int                        bit_cnt;
   logic [7:0]                run_xor;
   parse_phase_type           phase;
   logic [15:0]               field_acc;
   int                        field_left;
   logic [8:0]                run_len;
   logic [lzbd_pkg::WP_W-1:0] wr_ptr;
   logic [63:0]               lane_word;
   int                        lane_cnt;

   // compressed stream under construction
   bit         stream_bits[$];
   logic [7:0] section_bytes[$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void flush_lanes(logic done, lzbd_pkg::status_code_type st);
      out_word_type w;
      w.data  = lane_word;
      w.count = 4'(lane_cnt);
      w.done  = done;
      w.st    = st;
      expected_words.push_back(w);
      lane_word = '0;
      lane_cnt  = 0;
   endfunction

   function automatic void store_byte(logic [7:0] b);
      hist_mem[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
      bytes_left = bytes_left - 1;
      lane_word[8*lane_cnt +: 8] = b;
      lane_cnt++;
      if (lane_cnt >= lzbd_pkg::OUT_LANES) flush_lanes(1'b0, lzbd_pkg::STATUS_OK);
   endfunction

   function automatic void close_section(lzbd_pkg::status_code_type st);
      flush_lanes(1'b1, st);
      phase      = P_IDLE;
      field_left = 0;
      field_acc  = '0;
   endfunction

   function automatic void enter_phase(parse_phase_type ph, int nbits);
      phase      = ph;
      field_left = nbits;
      field_acc  = '0;
   endfunction

   function automatic void token_done();
      if (bytes_left == 0)
         close_section(run_xor != 0 ? lzbd_pkg::STATUS_CHECKSUM : lzbd_pkg::STATUS_OK);
      else enter_phase(P_HEAD1, 1);
   endfunction

   function automatic void shift_in(bit b);
      logic [15:0] v;
      int          off;
      field_acc = {field_acc[14:0], b};
      if (field_left > 0) field_left--;
      if (field_left != 0) return;
      v = field_acc;
      case (phase)
         P_HEAD1: begin
            if (v == 0) enter_phase(P_HEAD2S, 1);
            else enter_phase(P_HEAD2L, 2);
         end
         P_HEAD2S: begin
            if (v == 0) enter_phase(P_RAW3, 3);
            else begin
               run_len = 2;
               enter_phase(P_OFFSET, 8);
            end
         end
         P_HEAD2L: begin
            case (v[1:0])
               2'd0: begin run_len = 3; enter_phase(P_OFFSET, 9); end
               2'd1: begin run_len = 4; enter_phase(P_OFFSET, 10); end
               2'd2: enter_phase(P_LEN8, 8);
               default: enter_phase(P_RAW8, 8);
            endcase
         end
         P_LEN8: begin
            run_len = {1'b0, v[7:0]} + 9'd1;
            enter_phase(P_OFFSET, 12);
         end
         P_RAW3, P_RAW8: begin
            run_len = (phase == P_RAW3) ? {6'd0, v[2:0]} + 9'd1 : {1'b0, v[7:0]} + 9'd9;
            if (bytes_left < run_len) close_section(lzbd_pkg::STATUS_ERROR);
            else enter_phase(P_LITERAL, 8);
         end
         P_OFFSET: begin
            off = int'(v[11:0]) + 1;
            // offset must stay within bytes already produced in this section
            if (longint'(bytes_left) - 1 + off >= longint'(cfg_out_len)
                || bytes_left < run_len) begin
               close_section(lzbd_pkg::STATUS_ERROR);
            end else begin
               for (int i = 0; i < run_len; i++)
                  store_byte(hist_mem[wr_ptr - lzbd_pkg::WP_W'(off)]);
               token_done();
            end
         end
         P_LITERAL: begin
            store_byte(v[7:0]);
            run_len = run_len - 1'b1;
            if (run_len == 0) token_done();
            else enter_phase(P_LITERAL, 8);
         end
         default: phase = P_IDLE;
      endcase
   endfunction

   function automatic void decode_item(lzbd_pkg::command_type c, logic [7:0] b, logic last);
      lane_word = '0;
      lane_cnt  = 0;
      if (c == lzbd_pkg::CMD_START) begin
         bytes_left = cfg_out_len;
         run_xor    = cfg_seed;
         wr_ptr     = '0;
         run_len    = '0;
         if (cfg_out_len == 0) begin
            bit_buf = '0;
            bit_cnt = 0;
            close_section(lzbd_pkg::STATUS_OK);
            return;
         end
         enter_phase(P_HEAD1, 1);
         bit_buf = b;
         bit_cnt = cfg_first_bits > lzbd_pkg::FIRST_BITS_MAX ? 8 : int'(cfg_first_bits);
         run_xor ^= b;
      end else begin
         if (phase == P_IDLE) return;
         bit_buf = b;
         bit_cnt = 8;
         run_xor ^= b;
      end
      while (phase != P_IDLE) begin
         if (bit_cnt == 0) begin
            if (last) close_section(lzbd_pkg::STATUS_ERROR);
            break;
         end
         shift_in(bit_buf[0]);
         bit_buf = bit_buf >> 1;
         bit_cnt--;
      end
      if (lane_cnt > 0) flush_lanes(1'b0, lzbd_pkg::STATUS_OK);
   endfunction

   // result side: compare each accepted word and draw the next stall
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word: out_bytes=%h", rsp_ch.out_bytes);
            fail_count++;
         end else begin
            out_word_type w;
            w = expected_words.pop_front();
            if (rsp_ch.out_bytes !== w.data) begin
               $error("out_bytes: expected %h, got %h", w.data, rsp_ch.out_bytes);
               fail_count++;
            end
            if (rsp_ch.byte_count !== w.count) begin
               $error("byte_count: expected %0d, got %0d", w.count, rsp_ch.byte_count);
               fail_count++;
            end
            if (rsp_ch.section_done !== w.done) begin
               $error("section_done: expected %0d, got %0d", w.done, rsp_ch.section_done);
               fail_count++;
            end
            if (rsp_ch.status !== w.st) begin
               $error("status: expected %0d, got %0d", w.st, rsp_ch.status);
               fail_count++;
            end
         end
         rsp_gap = $urandom_range(0, 3);
         if ($urandom_range(0, 15) == 0) rsp_gap = 0;
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles--;
      end else if (rsp_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         stall_count = 0;
      end else begin
         stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(lzbd_pkg::command_type c, logic [7:0] b, logic last);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= c;
      req_ch.comp_byte  <= b;
      req_ch.final_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      decode_item(c, b, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(lzbd_pkg::csr_index_type idx, logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         lzbd_pkg::CSR_FIRST_BYTE_BITS: cfg_first_bits = value[3:0];
         lzbd_pkg::CSR_CHECKSUM_SEED:   cfg_seed = value[7:0];
         default:                       cfg_out_len = value;
      endcase
      @(negedge clock);
   endtask

   // wait for all results, then let any item without a result finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_regs(int fb, logic [7:0] seed, logic [31:0] len);
      settle();
      write_reg(lzbd_pkg::CSR_FIRST_BYTE_BITS, 32'(fb));
      write_reg(lzbd_pkg::CSR_CHECKSUM_SEED, 32'(seed));
      write_reg(lzbd_pkg::CSR_OUTPUT_LENGTH, len);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic void put_field(int unsigned value, int nbits);
      for (int i = nbits - 1; i >= 0; i--) stream_bits.push_back(value[i]);
   endfunction

   // random well-formed token sequence producing exactly len bytes
   function automatic void gen_tokens(int len);
      int done_bytes, left, kind, n, cap, off;
      done_bytes = 0;
      while (done_bytes < len) begin
         left = len - done_bytes;
         if (done_bytes > 0 && $urandom_range(0, 9) < 5) begin
            kind = $urandom_range(0, 3);
            n = kind + 2;
            if (kind < 3 && n > left) kind = 3;
            cap = (kind == 0) ? 256 : (kind == 1) ? 512 : (kind == 2) ? 1024 : 4096;
            if (cap > done_bytes) cap = done_bytes;
            off = $urandom_range(1, cap);
            case (kind)
               0: begin put_field(1, 2); put_field(off - 1, 8); end
               1: begin put_field(4, 3); put_field(off - 1, 9); end
               2: begin put_field(5, 3); put_field(off - 1, 10); end
               default: begin
                  n = $urandom_range(1, left < 256 ? left : 256);
                  put_field(6, 3);
                  put_field(n - 1, 8);
                  put_field(off - 1, 12);
               end
            endcase
         end else begin
            if (left >= 9 && $urandom_range(0, 3) == 0) begin
               n = $urandom_range(9, left < 264 ? left : 264);
               put_field(7, 3);
               put_field(n - 9, 8);
            end else begin
               n = $urandom_range(1, left < 8 ? left : 8);
               put_field(0, 2);
               put_field(n - 1, 3);
            end
            for (int i = 0; i < n; i++) put_field($urandom_range(0, 255), 8);
         end
         done_bytes += n;
      end
   endfunction

   // pack the bit stream into bytes and send it as one section;
   // keep > 0 sends at most that many bytes, cut_final marks the last one sent as final
   task automatic send_stream(int len, int fb, bit bad_seed, int keep, bit cut_final);
      logic [7:0] b, xs;
      int         fbe, n;
      section_bytes.delete();
      fbe = fb > 8 ? 8 : fb;
      b = 8'($urandom);
      for (int i = 0; i < fbe; i++) if (stream_bits.size() > 0) b[i] = stream_bits.pop_front();
      section_bytes.push_back(b);
      while (stream_bits.size() > 0) begin
         b = 8'($urandom);
         for (int i = 0; i < 8; i++) if (stream_bits.size() > 0) b[i] = stream_bits.pop_front();
         section_bytes.push_back(b);
      end
      n = (keep > 0 && keep < section_bytes.size()) ? keep : section_bytes.size();
      xs = '0;
      for (int i = 0; i < n; i++) xs ^= section_bytes[i];
      if (bad_seed) xs ^= 8'($urandom_range(1, 255));
      set_regs(fb, xs, 32'(len));
      for (int i = 0; i < n; i++)
         send_item(i == 0 ? lzbd_pkg::CMD_START : lzbd_pkg::CMD_CONTINUE, section_bytes[i],
                   i == n - 1 && (keep == 0 || cut_final));
   endtask

   task automatic test_empty_and_idle();
      set_regs(15, 8'hFF, 32'd0);
      send_item(lzbd_pkg::CMD_START, 8'hFF, 1'b1);
      send_item(lzbd_pkg::CMD_CONTINUE, 8'h00, 1'b0);
      send_item(lzbd_pkg::CMD_CONTINUE, 8'hA5, 1'b1);
      // huge section with noise, later abandoned by the next start
      set_regs(9, 8'h00, 32'hFFFF_FFFF);
      send_item(lzbd_pkg::CMD_START, 8'h00, 1'b0);
      send_item(lzbd_pkg::CMD_CONTINUE, 8'hFF, 1'b0);
      send_item(lzbd_pkg::CMD_CONTINUE, 8'h5A, 1'b0);
   endtask

   task automatic test_token_kinds();
      // raw 8, raw 9 of extreme bytes, then each copy form
      put_field(0, 2); put_field(7, 3);
      for (int i = 0; i < 8; i++) put_field(i, 8);
      put_field(7, 3); put_field(0, 8);
      for (int i = 0; i < 9; i++) put_field(i[0] ? 8'hFF : 8'h00, 8);
      put_field(1, 2); put_field(0, 8);
      put_field(4, 3); put_field(16, 9);
      put_field(5, 3); put_field(3, 10);
      put_field(6, 3); put_field(19, 8); put_field(25, 12);
      send_stream(46, 8, 1'b0, 0, 1'b0);
      gen_tokens(12);
      send_stream(12, 0, 1'b0, 0, 1'b0);
      gen_tokens(9);
      send_stream(9, 3, 1'b0, 0, 1'b0);
   endtask

   task automatic test_error_cases();
      // long raw run past the end
      put_field(7, 3); put_field(0, 8);
      send_stream(3, 8, 1'b0, 0, 1'b0);
      // short raw run past the end
      put_field(0, 2); put_field(7, 3);
      send_stream(2, 8, 1'b0, 0, 1'b0);
      // copy before any byte produced
      put_field(1, 2); put_field(0, 8);
      send_stream(4, 8, 1'b0, 0, 1'b0);
      // copy longer than what is left
      put_field(0, 2); put_field(0, 3); put_field(8'h3C, 8);
      put_field(6, 3); put_field(3, 8); put_field(0, 12);
      send_stream(3, 5, 1'b0, 0, 1'b0);
      // checksum mismatch
      gen_tokens(10);
      send_stream(10, 8, 1'b1, 0, 1'b0);
      // input runs out
      gen_tokens(20);
      send_stream(20, 8, 1'b0, 2, 1'b1);
      // section abandoned by a new start
      gen_tokens(30);
      send_stream(30, 7, 1'b0, 2, 1'b0);
      gen_tokens(5);
      send_stream(5, 8, 1'b0, 0, 1'b0);
   endtask

   task automatic test_backpressure();
      settle();
      hold_cycles = 1500;
      gen_tokens(400);
      send_stream(400, 8, 1'b0, 0, 1'b0);
   endtask

   task automatic test_random_sections();
      int len;
      while (items_sent < 290) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
         gen_tokens(len);
         send_stream(len, $urandom_range(0, 15), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 9) == 0 ? 1 + $urandom_range(0, 2) : 0,
                     $urandom_range(0, 1));
         if ($urandom_range(0, 7) == 0) begin
            for (int i = 0; i < 4; i++)
               send_item(lzbd_pkg::command_type'($urandom_range(0, 1)), 8'($urandom),
                         1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      fail_count        = 0;
      items_sent        = 0;
      rsp_gap           = 0;
      hold_cycles       = 0;
      stall_count       = 0;
      cfg_first_bits    = 4'd8;
      cfg_seed          = '0;
      cfg_out_len       = '0;
      phase             = P_IDLE;
      bytes_left        = '0;
      bit_buf           = '0;
      bit_cnt           = 0;
      run_xor           = '0;
      field_acc         = '0;
      field_left        = 0;
      run_len           = '0;
      wr_ptr            = '0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.command    = lzbd_pkg::CMD_START;
      req_ch.comp_byte  = '0;
      req_ch.final_byte = 1'b0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = lzbd_pkg::CSR_FIRST_BYTE_BITS;
      csr_ch.data       = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_and_idle();
      test_token_kinds();
      test_error_cases();
      test_backpressure();
      test_random_sections();

      settle();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
